// File: rtl/core/assert_macros.svh
// assertion helpers used by voxel_hash_map_accumulate_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/vhma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhma_pkg
// types and constants of the voxel hash map core
// ----------------------------------------------------------------------------
package vhma_pkg;

   localparam int CAPACITY  = 4096;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = IDX_W + 1;
   localparam int MAX_PROBE = 16;
   localparam int PROBE_W   = (MAX_PROBE > 1) ? $clog2(MAX_PROBE) : 1;
   localparam int COORD_W   = 24;
   localparam int INT_W     = 16;
   localparam int VSIZE_W   = 16;
   localparam int STEP_W    = $clog2(COORD_W);
   localparam int PT_W      = 3 * COORD_W + INT_W;
   localparam int KEY_W     = 3 * COORD_W;
   localparam int REC_W     = 1 + KEY_W + PT_W;
   localparam int REC_VALID = REC_W - 1;

   localparam logic [VSIZE_W-1:0] VSIZE_RESET = 16'd80;

   localparam logic [2:0] ST_NEW  = 3'd0;
   localparam logic [2:0] ST_UPD  = 3'd1;
   localparam logic [2:0] ST_DROP = 3'd2;
   localparam logic [2:0] ST_SKIP = 3'd3;
   localparam logic [2:0] ST_READ = 3'd4;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_LOAD,
      S_DIV_STEP,
      S_DIV_END,
      S_LOOKUP,
      S_CHECK,
      S_FINISH
   } state_type;

endpackage

// File: rtl/core/vhma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhma_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module vhma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/core/voxel_hash_map_accumulate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_hash_map_accumulate_core
// voxel keyed point map: serial floor division, hashing, linear probe table
// ----------------------------------------------------------------------------
// paths: a read looks up its given slot, a nonfinite insert goes straight to the
//   response, a finite insert divides three coordinates, then probes up to 16 slots
// throughput: one word at a time; the shared restoring divider and the single
//   table port work on one word; a new word is taken while a result waits
// reset: synchronous; afterwards a clearing pass over all CAPACITY (4096) slots
//   empties the table and no word is accepted, csr writes are taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module voxel_hash_map_accumulate_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,     // voxel_size
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_x, point_y, point_z, point_intensity, slot_index, zero pad
   input  logic [103:0] req_tdata,
   input  logic [1:0]   req_tuser,     // command, point_finite
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // slot_index, stored_x, stored_y, stored_z, stored_intensity, voxel_count, pad
   output logic [119:0] rsp_tdata,
   output logic [3:0]   rsp_tuser      // status, slot_valid
);
   import vhma_pkg::*;

   state_type state_ff, state_in;

   logic [VSIZE_W-1:0] vsize_ff;
   logic [VSIZE_W-1:0] div_ff;
   logic               cmd_ff;
   logic [PT_W-1:0]    pt_ff;
   logic [IDX_W-1:0]   slot_ff;
   logic [PROBE_W-1:0] probe_ff;
   logic [1:0]         sel_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [VSIZE_W-1:0] rem_ff;
   logic [COORD_W-1:0] quo_ff;
   logic               neg_ff;
   logic [COORD_W-1:0] kx_ff, ky_ff, kz_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [2:0]         res_status_ff;
   logic [IDX_W-1:0]   res_slot_ff;
   logic               res_valid_ff;
   logic [PT_W-1:0]    res_pt_ff;
   logic               rsp_tvalid_ff;
   logic [119:0]       rsp_tdata_ff;
   logic [3:0]         rsp_tuser_ff;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [REC_W-1:0]   ram_wdata;
   logic [REC_W-1:0]   ram_rdata;

   logic               accept;
   logic               rsp_free;
   logic               rsp_load;
   logic [COORD_W-1:0] coord;
   logic [VSIZE_W:0]   trial;
   logic               trial_ge;
   logic [VSIZE_W:0]   trial_sub;
   logic [COORD_W-1:0] key_val;
   logic [IDX_W-1:0]   hash;
   logic               rd_valid;
   logic               key_hit;
   logic               last_probe;

   vhma_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (slot_ff),
      .rd_data (ram_rdata)
   );

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load = (state_ff == S_FINISH) && rsp_free;

   // coordinate under division
   always_comb begin
      case (sel_ff)
         2'd0:    coord = pt_ff[COORD_W-1:0];
         2'd1:    coord = pt_ff[2*COORD_W-1:COORD_W];
         default: coord = pt_ff[3*COORD_W-1:2*COORD_W];
      endcase
   end

   // one restoring divider step
   assign trial     = {rem_ff, quo_ff[COORD_W-1]};
   assign trial_ge  = trial >= {1'b0, div_ff};
   assign trial_sub = trial - {1'b0, div_ff};

   // floor: negative with remainder rounds down one more
   always_comb begin
      if (!neg_ff) begin
         key_val = quo_ff;
      end else if (rem_ff != '0) begin
         key_val = ~quo_ff;
      end else begin
         key_val = -quo_ff;
      end
   end

   // z key taken straight from the divider as it finishes
   assign hash = kx_ff[IDX_W-1:0] ^ {ky_ff[IDX_W-2:0], 1'b0}
               ^ {key_val[IDX_W-3:0], 2'b00};

   assign rd_valid   = ram_rdata[REC_VALID];
   assign key_hit    = ram_rdata[REC_VALID-1:PT_W] == {kz_ff, ky_ff, kx_ff};
   assign last_probe = probe_ff == PROBE_W'(MAX_PROBE - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (slot_ff == IDX_W'(CAPACITY - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_tuser[0] == CMD_READ) state_in = S_LOOKUP;
               else if (!req_tuser[1])       state_in = S_FINISH;
               else                          state_in = S_DIV_LOAD;
            end
         end
         S_DIV_LOAD: state_in = S_DIV_STEP;
         S_DIV_STEP: begin
            if (step_ff == STEP_W'(COORD_W - 1)) state_in = S_DIV_END;
         end
         S_DIV_END: begin
            state_in = (sel_ff == 2'd2) ? S_LOOKUP : S_DIV_LOAD;
         end
         S_LOOKUP: state_in = S_CHECK;
         S_CHECK: begin
            if (cmd_ff == CMD_READ || !rd_valid || key_hit || last_probe) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_LOOKUP;
            end
         end
         S_FINISH: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = slot_ff;
      ram_wdata  = '0;
      case (state_ff)
         S_CLEAR: ram_we = 1'b1;
         S_IDLE:  req_tready = 1'b1;
         S_CHECK: begin
            if (cmd_ff == CMD_INSERT && (!rd_valid || key_hit)) begin
               ram_we    = 1'b1;
               ram_wdata = {1'b1, kz_ff, ky_ff, kx_ff, pt_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         vsize_ff      <= VSIZE_RESET;
         slot_ff       <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) vsize_ff <= csr_wdata;
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: slot_ff <= slot_ff + 1'b1;
            S_IDLE: begin
               if (accept) begin
                  cmd_ff        <= req_tuser[0];
                  pt_ff         <= req_tdata[PT_W-1:0];
                  slot_ff       <= req_tdata[PT_W+IDX_W-1:PT_W];
                  div_ff        <= (vsize_ff == '0) ? VSIZE_W'(1) : vsize_ff;
                  sel_ff        <= 2'd0;
                  probe_ff      <= '0;
                  res_status_ff <= ST_SKIP;
                  res_slot_ff   <= '0;
                  res_valid_ff  <= 1'b0;
                  res_pt_ff     <= '0;
               end
            end
            S_DIV_LOAD: begin
               neg_ff  <= coord[COORD_W-1];
               quo_ff  <= coord[COORD_W-1] ? -coord : coord;
               rem_ff  <= '0;
               step_ff <= '0;
            end
            S_DIV_STEP: begin
               rem_ff  <= trial_ge ? trial_sub[VSIZE_W-1:0] : trial[VSIZE_W-1:0];
               quo_ff  <= {quo_ff[COORD_W-2:0], trial_ge};
               step_ff <= step_ff + 1'b1;
            end
            S_DIV_END: begin
               case (sel_ff)
                  2'd0:    kx_ff <= key_val;
                  2'd1:    ky_ff <= key_val;
                  default: kz_ff <= key_val;
               endcase
               if (sel_ff == 2'd2) slot_ff <= hash;
               sel_ff <= sel_ff + 1'b1;
            end
            S_CHECK: begin
               if (cmd_ff == CMD_READ) begin
                  res_status_ff <= ST_READ;
                  res_slot_ff   <= slot_ff;
                  res_valid_ff  <= rd_valid;
                  res_pt_ff     <= rd_valid ? ram_rdata[PT_W-1:0] : '0;
               end else if (!rd_valid || key_hit) begin
                  res_status_ff <= rd_valid ? ST_UPD : ST_NEW;
                  res_slot_ff   <= slot_ff;
                  res_valid_ff  <= 1'b1;
                  res_pt_ff     <= pt_ff;
                  if (!rd_valid) count_ff <= count_ff + 1'b1;
               end else if (last_probe) begin
                  res_status_ff <= ST_DROP;
               end else begin
                  slot_ff  <= slot_ff + 1'b1;
                  probe_ff <= probe_ff + 1'b1;
               end
            end
            S_FINISH: begin
               if (rsp_free) begin
                  rsp_tuser_ff  <= {res_valid_ff, res_status_ff};
                  rsp_tdata_ff  <= {7'b0, count_ff, res_pt_ff, res_slot_ff};
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `ASSERT_NEXT(a_count_new, clock, reset,
      state_ff == S_CHECK && cmd_ff == CMD_INSERT && !rd_valid,
      count_ff == $past(count_ff) + 1'b1)
   `ASSERT_IMP(a_drop_empty, clock, reset,
      state_ff == S_FINISH && res_status_ff == ST_DROP,
      !res_valid_ff && res_slot_ff == '0)
   `ASSERT_NEXT(a_div_len, clock, reset,
      state_ff == S_DIV_LOAD, state_ff == S_DIV_STEP && step_ff == '0)

endmodule
